// ===== rtl/mhw_pkg.sv =====
package mhw_pkg;

  // Entry addresses travel at a width that covers a table of up to 64 entries
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 9;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [LEN_W-1:0] MAX_LEN       = 9'd256;
  localparam logic [LEN_W-1:0] MIN_HDR_RESET = 9'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HDR_LEN = 2'd1;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_CRC     = 3'd0,
    KIND_HEARD   = 3'd1,
    KIND_RUNT    = 3'd2,
    KIND_WRITTEN = 3'd3,
    KIND_REJECT  = 3'd4,
    KIND_READ    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [31:0]        seen_ms;
    logic [31:0]        packets;
    logic signed [10:0] level;
    logic [31:0]        direct_ms;
    logic signed [10:0] direct_level;
  } row_t;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e              kind;
    logic signed [3:0]  hops;
    logic               watch_hit;
    logic [3:0]         out_index;
    logic [IDX_W-1:0]   addr;
    logic               direct;
    logic [31:0]        heard_count;
    logic [31:0]        crc_error_count;
    logic [31:0]        runt_count;
    logic [31:0]        now_ms;
    logic signed [10:0] rssi;
  } op_t;

endpackage

// ===== rtl/mhw_intf.sv =====
interface mhw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               rx_crc_error;
  logic [8:0]         pkt_len;
  logic [31:0]        dest_id;
  logic [31:0]        src_id;
  logic [7:0]         hop_flags;
  logic [7:0]         chan_hash;
  logic signed [10:0] rssi_half_db;
  logic signed [7:0]  snr_quarter_db;
  logic [31:0]        now_ms;
  logic [3:0]         entry_index;
  logic [31:0]        entry_id;

  modport source (
    output valid, command, rx_crc_error, pkt_len, dest_id, src_id, hop_flags, chan_hash,
    output rssi_half_db, snr_quarter_db, now_ms, entry_index, entry_id,
    input  ready
  );
  modport sink (
    input  valid, command, rx_crc_error, pkt_len, dest_id, src_id, hop_flags, chan_hash,
    input  rssi_half_db, snr_quarter_db, now_ms, entry_index, entry_id,
    output ready
  );
endinterface

interface mhw_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [3:0]  hops;
  logic               watch_hit;
  logic [3:0]         hit_index;
  logic [31:0]        heard_count;
  logic [31:0]        crc_error_count;
  logic [31:0]        runt_count;
  logic [31:0]        entry_last_ms;
  logic [31:0]        entry_packets;
  logic signed [10:0] entry_rssi;
  logic [31:0]        entry_direct_ms;
  logic signed [10:0] entry_direct_rssi;

  modport source (
    output valid, kind, hops, watch_hit, hit_index, heard_count, crc_error_count, runt_count,
    output entry_last_ms, entry_packets, entry_rssi, entry_direct_ms, entry_direct_rssi,
    input  ready
  );
  modport sink (
    input  valid, kind, hops, watch_hit, hit_index, heard_count, crc_error_count, runt_count,
    input  entry_last_ms, entry_packets, entry_rssi, entry_direct_ms, entry_direct_rssi,
    output ready
  );
endinterface

// ===== rtl/mesh_header_watch_monitor.sv =====
// Path: an accepted item passes capture, id compare, classify into the queue, stats RAM read,
// then update and output register.
// Flow: the back end takes no new item until its read then write of the stats RAM is done;
// the front end and the 2-entry queue absorb short bursts.
// Reset: counters, watch ids and row valid bits clear at once; watch_count resets to 0 and
// min_header_len to 16. No clearing pass, items are accepted right after reset.
module mesh_header_watch_monitor #(
  parameter int unsigned WATCH_ENTRIES = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mhw_in_if.sink                          in_i,
  mhw_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [mhw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mhw_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import mhw_pkg::*;

  logic [3:0]       watch_count_q;
  logic [LEN_W-1:0] min_hdr_len_q;

  logic op_valid, op_ready, q_valid, q_ready;
  op_t  op_front, op_back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_count_q <= '0;
      min_hdr_len_q <= MIN_HDR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WATCH_COUNT: watch_count_q <= cfg_wdata_i[3:0];
        CFG_MIN_HDR_LEN: min_hdr_len_q <= cfg_wdata_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mhw_front #(
    .WATCH_ENTRIES (WATCH_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .watch_count_i (watch_count_q),
    .min_hdr_len_i (min_hdr_len_q),
    .op_valid_o    (op_valid),
    .op_o          (op_front),
    .op_ready_i    (op_ready)
  );

  mhw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (op_valid),
    .push_data_i  (op_front),
    .push_ready_o (op_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (op_back),
    .pop_ready_i  (q_ready)
  );

  mhw_back #(
    .WATCH_ENTRIES (WATCH_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (op_back),
    .op_ready_o (q_ready),
    .out_o      (out_o)
  );

endmodule

// ===== rtl/mhw_ram.sv =====
module mhw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mhw_queue.sv =====
module mhw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  mhw_pkg::op_t   push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output mhw_pkg::op_t   pop_data_o,
  input  logic           pop_ready_i
);
  import mhw_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mhw_front.sv =====
module mhw_front #(
  parameter int unsigned WATCH_ENTRIES = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mhw_in_if.sink                       in_i,
  input  logic [3:0]                   watch_count_i,
  input  logic [mhw_pkg::LEN_W-1:0]    min_hdr_len_i,
  output logic                         op_valid_o,
  output mhw_pkg::op_t                 op_o,
  input  logic                         op_ready_i
);
  import mhw_pkg::*;

  localparam int unsigned EW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

  // stage 0: captured item
  logic               s0_valid_q;
  cmd_e               s0_cmd_q;
  logic               s0_crc_q;
  logic [LEN_W-1:0]   s0_len_q;
  logic [31:0]        s0_src_q;
  logic [7:0]         s0_flags_q;
  logic signed [10:0] s0_rssi_q;
  logic [31:0]        s0_now_q;
  logic [3:0]         s0_idx_q;
  logic [31:0]        s0_id_q;

  // stage 1: id compare done
  logic                     s1_valid_q;
  cmd_e                     s1_cmd_q;
  logic                     s1_crc_q;
  logic [LEN_W-1:0]         s1_len_q;
  logic [7:0]               s1_flags_q;
  logic signed [10:0]       s1_rssi_q;
  logic [31:0]              s1_now_q;
  logic [3:0]               s1_idx_q;
  logic                     s1_reject_q;
  logic [WATCH_ENTRIES-1:0] s1_match_q;

  logic [31:0] ids_q [WATCH_ENTRIES];
  logic [31:0] heard_q, crc_q, runt_q;
  logic [31:0] heard_d, crc_d, runt_d;

  logic                     s1_free, s1_adv, s0_adv, push;
  logic                     s0_in_range, s0_reject, s0_id_load;
  logic [WATCH_ENTRIES-1:0] match_d;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [LEN_W-1:0]         len_c;
  logic [2:0]               flag_limit, flag_start;
  logic                     known;
  op_t                      op_d;

  assign push    = s1_valid_q && (s1_cmd_q != CMD_NONE) && op_ready_i;
  assign s1_adv  = s1_valid_q && ((s1_cmd_q == CMD_NONE) || op_ready_i);
  assign s1_free = !s1_valid_q || s1_adv;
  assign s0_adv  = s0_valid_q && s1_free;
  assign in_i.ready = !s0_valid_q || s1_free;

  assign s0_in_range = ({28'd0, s0_idx_q} < 32'(WATCH_ENTRIES));
  assign s0_reject   = !s0_in_range || ((s0_cmd_q == CMD_WRITE) && (s0_id_q == '0));
  assign s0_id_load  = s0_adv && (s0_cmd_q == CMD_WRITE) && !s0_reject;

  always_comb begin
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      match_d[i] = (32'(i) < {28'd0, watch_count_i}) && (ids_q[i] == s0_src_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      heard_q    <= '0;
      crc_q      <= '0;
      runt_q     <= '0;
      for (int i = 0; i < WATCH_ENTRIES; i++) begin
        ids_q[i] <= '0;
      end
    end else begin
      if (in_i.valid && in_i.ready) begin
        s0_valid_q <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_q <= 1'b0;
      end
      if (s0_adv) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s0_id_load) begin
        ids_q[EW'(s0_idx_q)] <= s0_id_q;
      end
      if (push) begin
        heard_q <= heard_d;
        crc_q   <= crc_d;
        runt_q  <= runt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_cmd_q   <= cmd_e'(in_i.command);
      s0_crc_q   <= in_i.rx_crc_error;
      s0_len_q   <= in_i.pkt_len;
      s0_src_q   <= in_i.src_id;
      s0_flags_q <= in_i.hop_flags;
      s0_rssi_q  <= in_i.rssi_half_db;
      s0_now_q   <= in_i.now_ms;
      s0_idx_q   <= in_i.entry_index;
      s0_id_q    <= in_i.entry_id;
    end
    if (s0_adv) begin
      s1_cmd_q    <= s0_cmd_q;
      s1_crc_q    <= s0_crc_q;
      s1_len_q    <= s0_len_q;
      s1_flags_q  <= s0_flags_q;
      s1_rssi_q   <= s0_rssi_q;
      s1_now_q    <= s0_now_q;
      s1_idx_q    <= s0_idx_q;
      s1_reject_q <= s0_reject;
      s1_match_q  <= match_d;
    end
  end

  // lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WATCH_ENTRIES - 1; i >= 0; i--) begin
      if (s1_match_q[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign len_c      = (s1_len_q > MAX_LEN) ? MAX_LEN : s1_len_q;
  assign flag_limit = s1_flags_q[2:0];
  assign flag_start = s1_flags_q[7:5];
  assign known      = (flag_start >= flag_limit);

  always_comb begin
    heard_d = heard_q;
    crc_d   = crc_q;
    runt_d  = runt_q;
    op_d    = '0;
    op_d.kind   = KIND_CRC;
    op_d.hops   = -4'sd1;
    op_d.now_ms = s1_now_q;
    op_d.rssi   = s1_rssi_q;
    case (s1_cmd_q)
      CMD_PACKET: begin
        if (s1_crc_q) begin
          crc_d     = crc_q + 32'd1;
          op_d.kind = KIND_CRC;
        end else if (len_c < min_hdr_len_i) begin
          runt_d    = runt_q + 32'd1;
          op_d.kind = KIND_RUNT;
        end else begin
          heard_d        = heard_q + 32'd1;
          op_d.kind      = KIND_HEARD;
          op_d.hops      = known ? $signed({1'b0, flag_start - flag_limit}) : -4'sd1;
          op_d.direct    = known && (flag_start == flag_limit);
          op_d.watch_hit = hit;
          op_d.out_index = hit ? 4'(hit_idx) : 4'd0;
          op_d.addr      = hit_idx;
        end
      end
      CMD_WRITE: begin
        op_d.kind      = s1_reject_q ? KIND_REJECT : KIND_WRITTEN;
        op_d.out_index = s1_idx_q;
        op_d.addr      = s1_reject_q ? '0 : IDX_W'(s1_idx_q);
      end
      CMD_READ: begin
        op_d.kind      = s1_reject_q ? KIND_REJECT : KIND_READ;
        op_d.out_index = s1_idx_q;
        op_d.addr      = s1_reject_q ? '0 : IDX_W'(s1_idx_q);
      end
      default: begin
      end
    endcase
    op_d.heard_count     = heard_d;
    op_d.crc_error_count = crc_d;
    op_d.runt_count      = runt_d;
  end

  assign op_valid_o = s1_valid_q && (s1_cmd_q != CMD_NONE);
  assign op_o       = op_d;

endmodule

// ===== rtl/mhw_back.sv =====
module mhw_back #(
  parameter int unsigned WATCH_ENTRIES = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  mhw_pkg::op_t  op_i,
  output logic          op_ready_o,
  mhw_out_if.source     out_o
);
  import mhw_pkg::*;

  localparam int unsigned EW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;
  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_UPD  = 1'b1;

  logic                     state_q, state_d;
  op_t                      op_q;
  logic [WATCH_ENTRIES-1:0] row_valid_q;
  row_t                     rd_row, old_row, new_row;
  logic [EW-1:0]            rd_addr, op_addr;
  logic                     take, commit, out_free, ram_we;

  logic               out_valid_q;
  kind_e              out_kind_q;
  logic signed [3:0]  out_hops_q;
  logic               out_hit_q;
  logic [3:0]         out_index_q;
  logic [31:0]        out_heard_q, out_crc_q, out_runt_q;
  logic [31:0]        out_last_ms_q, out_packets_q, out_direct_ms_q;
  logic signed [10:0] out_rssi_q, out_direct_rssi_q;

  assign take       = (state_q == BK_IDLE) && op_valid_i;
  assign op_ready_o = (state_q == BK_IDLE);
  assign rd_addr    = EW'(op_i.addr);
  assign op_addr    = EW'(op_q.addr);
  assign out_free   = !out_valid_q || out_o.ready;
  assign commit     = (state_q == BK_UPD) && out_free;
  assign ram_we     = commit && (((op_q.kind == KIND_HEARD) && op_q.watch_hit) ||
                                 (op_q.kind == KIND_WRITTEN));

  mhw_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (WATCH_ENTRIES)
  ) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_addr),
    .wdata_i (new_row),
    .re_i    (take),
    .raddr_i (rd_addr),
    .rdata_o (rd_row)
  );

  // never-written rows read as zero
  assign old_row = row_valid_q[op_addr] ? rd_row : '0;

  always_comb begin
    new_row = old_row;
    case (op_q.kind)
      KIND_HEARD: begin
        new_row.seen_ms = op_q.now_ms;
        new_row.packets = old_row.packets + 32'd1;
        new_row.level   = op_q.rssi;
        if (op_q.direct) begin
          new_row.direct_ms    = op_q.now_ms;
          new_row.direct_level = op_q.rssi;
        end
      end
      KIND_WRITTEN: new_row = '0;
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (take) state_d = BK_UPD;
      BK_UPD:  if (commit) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        row_valid_q[op_addr] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= op_i;
    end
    if (commit) begin
      out_kind_q  <= op_q.kind;
      out_hops_q  <= op_q.hops;
      out_hit_q   <= op_q.watch_hit;
      out_index_q <= op_q.out_index;
      out_heard_q <= op_q.heard_count;
      out_crc_q   <= op_q.crc_error_count;
      out_runt_q  <= op_q.runt_count;
      if (op_q.kind == KIND_READ) begin
        out_last_ms_q     <= old_row.seen_ms;
        out_packets_q     <= old_row.packets;
        out_rssi_q        <= old_row.level;
        out_direct_ms_q   <= old_row.direct_ms;
        out_direct_rssi_q <= old_row.direct_level;
      end else begin
        out_last_ms_q     <= '0;
        out_packets_q     <= '0;
        out_rssi_q        <= '0;
        out_direct_ms_q   <= '0;
        out_direct_rssi_q <= '0;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.kind              = out_kind_q;
  assign out_o.hops              = out_hops_q;
  assign out_o.watch_hit         = out_hit_q;
  assign out_o.hit_index         = out_index_q;
  assign out_o.heard_count       = out_heard_q;
  assign out_o.crc_error_count   = out_crc_q;
  assign out_o.runt_count        = out_runt_q;
  assign out_o.entry_last_ms     = out_last_ms_q;
  assign out_o.entry_packets     = out_packets_q;
  assign out_o.entry_rssi        = out_rssi_q;
  assign out_o.entry_direct_ms   = out_direct_ms_q;
  assign out_o.entry_direct_rssi = out_direct_rssi_q;

`ifndef NO_ASSERTIONS
  a_take_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE && op_valid_i) |=> (state_q == BK_UPD))
    else $error("back did not enter update after taking an item");

  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == BK_UPD && out_free))
    else $error("stats write outside commit");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> row_valid_q[$past(op_addr)])
    else $error("written row not marked valid");

  a_stats_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KIND_READ) |->
      (out_packets_q == '0 && out_last_ms_q == '0 && out_direct_ms_q == '0))
    else $error("entry stats on a non-read result");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhw_pkg::*;

  localparam int unsigned ENTRIES      = 12;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned LONG_HOLD    = 160;
  localparam int unsigned SETTLE       = 10;
  localparam int unsigned DRAIN_CAP    = 20000;

  typedef struct packed {
    cmd_e               command;
    logic               rx_crc_error;
    logic [8:0]         pkt_len;
    logic [31:0]        dest_id;
    logic [31:0]        src_id;
    logic [7:0]         hop_flags;
    logic [7:0]         chan_hash;
    logic signed [10:0] rssi_half_db;
    logic signed [7:0]  snr_quarter_db;
    logic [31:0]        now_ms;
    logic [3:0]         entry_index;
    logic [31:0]        entry_id;
  } rx_item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [3:0]  hops;
    logic               watch_hit;
    logic [3:0]         hit_index;
    logic [31:0]        heard_count;
    logic [31:0]        crc_error_count;
    logic [31:0]        runt_count;
    logic [31:0]        entry_last_ms;
    logic [31:0]        entry_packets;
    logic signed [10:0] entry_rssi;
    logic [31:0]        entry_direct_ms;
    logic signed [10:0] entry_direct_rssi;
  } report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mhw_in_if  in_if ();
  mhw_out_if out_if ();

  mesh_header_watch_monitor #(
    .WATCH_ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow of the block: configuration, counters and watch table
  logic [3:0]         watch_count_q;
  logic [8:0]         min_len_q;
  logic [31:0]        heard_total;
  logic [31:0]        crc_total;
  logic [31:0]        runt_total;
  logic [31:0]        watch_id     [ENTRIES];
  logic [31:0]        watch_seen   [ENTRIES];
  logic [31:0]        watch_pkts   [ENTRIES];
  logic signed [10:0] watch_rssi   [ENTRIES];
  logic [31:0]        direct_seen  [ENTRIES];
  logic signed [10:0] direct_rssi  [ENTRIES];

  rx_item_t    items_to_send [$];
  report_t     expected_reports [$];
  logic [31:0] known_ids [$];
  rx_item_t    on_bus;

  logic        in_taken;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned stall_left;
  bit          hold_armed;
  bit          hold_done;
  int unsigned hold_cycles;

  int unsigned mismatches;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned watch_hits;
  int unsigned reg_writes;
  int unsigned kind_tally [6];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, expected_reports.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit classify_event(input rx_item_t it, output report_t r);
    logic [8:0]  len;
    logic [2:0]  flag_limit;
    logic [2:0]  flag_start;
    logic        known;
    int unsigned searched;
    bit          produced;
    r          = '0;
    r.hops     = -4'sd1;
    produced   = 1'b1;
    len        = (it.pkt_len > MAX_LEN) ? MAX_LEN : it.pkt_len;
    flag_limit = it.hop_flags[2:0];
    flag_start = it.hop_flags[7:5];
    known      = flag_start >= flag_limit;
    searched   = (watch_count_q > ENTRIES) ? ENTRIES : watch_count_q;
    case (it.command)
      CMD_PACKET: begin
        if (it.rx_crc_error) begin
          crc_total = crc_total + 32'd1;
          r.kind    = KIND_CRC;
        end else if (len < min_len_q) begin
          runt_total = runt_total + 32'd1;
          r.kind     = KIND_RUNT;
        end else begin
          heard_total = heard_total + 32'd1;
          r.kind      = KIND_HEARD;
          if (known) r.hops = {1'b0, 3'(flag_start - flag_limit)};
          for (int i = 0; i < searched; i++) begin
            if (!r.watch_hit && watch_id[i] == it.src_id) begin
              watch_seen[i] = it.now_ms;
              watch_pkts[i] = watch_pkts[i] + 32'd1;
              watch_rssi[i] = it.rssi_half_db;
              if (known && flag_start == flag_limit) begin
                direct_seen[i] = it.now_ms;
                direct_rssi[i] = it.rssi_half_db;
              end
              r.watch_hit = 1'b1;
              r.hit_index = 4'(i);
            end
          end
        end
      end
      CMD_WRITE: begin
        r.hit_index = it.entry_index;
        if (it.entry_index >= ENTRIES || it.entry_id == 32'd0) begin
          r.kind = KIND_REJECT;
        end else begin
          watch_id[it.entry_index]    = it.entry_id;
          watch_seen[it.entry_index]  = '0;
          watch_pkts[it.entry_index]  = '0;
          watch_rssi[it.entry_index]  = '0;
          direct_seen[it.entry_index] = '0;
          direct_rssi[it.entry_index] = '0;
          r.kind = KIND_WRITTEN;
        end
      end
      CMD_READ: begin
        r.hit_index = it.entry_index;
        if (it.entry_index >= ENTRIES) begin
          r.kind = KIND_REJECT;
        end else begin
          r.kind              = KIND_READ;
          r.entry_last_ms     = watch_seen[it.entry_index];
          r.entry_packets     = watch_pkts[it.entry_index];
          r.entry_rssi        = watch_rssi[it.entry_index];
          r.entry_direct_ms   = direct_seen[it.entry_index];
          r.entry_direct_rssi = direct_rssi[it.entry_index];
        end
      end
      default: produced = 1'b0;
    endcase
    r.heard_count     = heard_total;
    r.crc_error_count = crc_total;
    r.runt_count      = runt_total;
    return produced;
  endfunction

  function automatic rx_item_t noise_item();
    rx_item_t it;
    it.command        = CMD_PACKET;
    it.rx_crc_error   = 1'($urandom);
    it.pkt_len        = 9'($urandom);
    it.dest_id        = $urandom;
    it.src_id         = $urandom;
    it.hop_flags      = 8'($urandom);
    it.chan_hash      = 8'($urandom);
    it.rssi_half_db   = 11'($urandom_range(0, 800)) - 11'd600;
    it.snr_quarter_db = 8'($urandom);
    it.now_ms         = $urandom;
    it.entry_index    = 4'($urandom);
    it.entry_id       = $urandom;
    return it;
  endfunction

  function automatic rx_item_t pkt_item(input logic crc, input logic [8:0] len,
                                        input logic [31:0] src, input logic [7:0] flags);
    rx_item_t it;
    it              = noise_item();
    it.rx_crc_error = crc;
    it.pkt_len      = len;
    it.src_id       = src;
    it.hop_flags    = flags;
    return it;
  endfunction

  function automatic rx_item_t entry_item(input cmd_e cmd, input logic [3:0] idx,
                                          input logic [31:0] id);
    rx_item_t it;
    it             = noise_item();
    it.command     = cmd;
    it.entry_index = idx;
    it.entry_id    = id;
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_WATCH_COUNT) watch_count_q = data[3:0];
    else if (idx == CFG_MIN_HDR_LEN) min_len_q = data;
    reg_writes++;
  endtask

  // wait for the block to go quiet; ignored items leave no expectation, so settle after
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((items_to_send.size() != 0 || in_if.valid || expected_reports.size() != 0)
           && waited < DRAIN_CAP) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // sender: bursts of items with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // item still waiting for ready
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (items_to_send.size() > 0) begin
      on_bus = items_to_send.pop_front();
      in_if.valid          <= 1'b1;
      in_if.command        <= on_bus.command;
      in_if.rx_crc_error   <= on_bus.rx_crc_error;
      in_if.pkt_len        <= on_bus.pkt_len;
      in_if.dest_id        <= on_bus.dest_id;
      in_if.src_id         <= on_bus.src_id;
      in_if.hop_flags      <= on_bus.hop_flags;
      in_if.chan_hash      <= on_bus.chan_hash;
      in_if.rssi_half_db   <= on_bus.rssi_half_db;
      in_if.snr_quarter_db <= on_bus.snr_quarter_db;
      in_if.now_ms         <= on_bus.now_ms;
      in_if.entry_index    <= on_bus.entry_index;
      in_if.entry_id       <= on_bus.entry_id;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0, 1, 2: gap_left = 0;
          3: begin
            gap_left   = 0;
            burst_left = $urandom_range(20, 60);
          end
          9: gap_left = $urandom_range(5, 15);
          default: gap_left = $urandom_range(1, 3);
        endcase
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off once armed
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      if (hold_cycles >= LONG_HOLD) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b1;
      end else begin
        hold_cycles++;
        out_if.ready <= 1'b0;
      end
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (stall_mode)
        2: out_if.ready <= 1'($urandom);
        3: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // results are checked before the item of this edge is predicted
  always @(posedge clk_i) begin
    report_t want;
    report_t predicted;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing expected, kind %0d", $time, out_if.kind);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("kind",              want.kind,              out_if.kind);
          check_field("hops",              want.hops,              out_if.hops);
          check_field("watch_hit",         want.watch_hit,         out_if.watch_hit);
          check_field("hit_index",         want.hit_index,         out_if.hit_index);
          check_field("heard_count",       want.heard_count,       out_if.heard_count);
          check_field("crc_error_count",   want.crc_error_count,   out_if.crc_error_count);
          check_field("runt_count",        want.runt_count,        out_if.runt_count);
          check_field("entry_last_ms",     want.entry_last_ms,     out_if.entry_last_ms);
          check_field("entry_packets",     want.entry_packets,     out_if.entry_packets);
          check_field("entry_rssi",        want.entry_rssi,        out_if.entry_rssi);
          check_field("entry_direct_ms",   want.entry_direct_ms,   out_if.entry_direct_ms);
          check_field("entry_direct_rssi", want.entry_direct_rssi, out_if.entry_direct_rssi);
          results_checked++;
          kind_tally[want.kind]++;
          if (want.watch_hit) watch_hits++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        items_accepted++;
        if (classify_event(on_bus, predicted)) expected_reports.push_back(predicted);
      end
    end
    in_taken <= rst_ni && in_if.valid && in_if.ready;
  end

  initial begin
    rx_item_t    it;
    int unsigned wc_plan [PHASES];
    int unsigned len_plan [PHASES];
    int unsigned phase_sent;
    int unsigned pick;
    int unsigned roll;
    int unsigned seq_idx;
    logic [31:0] seq_id;

    wc_plan              = '{12, 15, 0, 3, 13, 12, 7, 1};
    len_plan             = '{16, 0, 511, 20, 256, 64, 1, 257};
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_wdata_i          = '0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_PACKET;
    in_if.rx_crc_error   = 1'b0;
    in_if.pkt_len        = '0;
    in_if.dest_id        = '0;
    in_if.src_id         = '0;
    in_if.hop_flags      = '0;
    in_if.chan_hash      = '0;
    in_if.rssi_half_db   = '0;
    in_if.snr_quarter_db = '0;
    in_if.now_ms         = '0;
    in_if.entry_index    = '0;
    in_if.entry_id       = '0;
    out_if.ready         = 1'b0;
    in_taken             = 1'b0;
    burst_left           = 1;
    gap_left             = 0;
    stall_mode           = 0;
    stall_left           = 0;
    hold_armed           = 1'b0;
    hold_done            = 1'b0;
    hold_cycles          = 0;
    mismatches           = 0;
    items_accepted       = 0;
    results_checked      = 0;
    watch_hits           = 0;
    reg_writes           = 0;
    foreach (kind_tally[k]) kind_tally[k] = 0;
    watch_count_q = '0;
    min_len_q     = MIN_HDR_RESET;
    heard_total   = '0;
    crc_total     = '0;
    runt_total    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      watch_id[i]    = '0;
      watch_seen[i]  = '0;
      watch_pkts[i]  = '0;
      watch_rssi[i]  = '0;
      direct_seen[i] = '0;
      direct_rssi[i] = '0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, nothing searched yet
    items_to_send.push_back(entry_item(CMD_READ, 4'd0, 32'd0));
    items_to_send.push_back(pkt_item(1'b1, 9'd0, 32'd0, 8'h00));
    items_to_send.push_back(pkt_item(1'b0, 9'd0, 32'd0, 8'h00));
    items_to_send.push_back(pkt_item(1'b0, 9'd15, 32'd0, 8'h00));
    items_to_send.push_back(pkt_item(1'b0, 9'd16, 32'd0, 8'hE0));
    items_to_send.push_back(pkt_item(1'b0, 9'd256, 32'd0, 8'h07));
    items_to_send.push_back(pkt_item(1'b0, 9'd511, 32'd0, 8'hFF));
    items_to_send.push_back(entry_item(CMD_WRITE, 4'd0, 32'd0));
    items_to_send.push_back(entry_item(CMD_WRITE, 4'd12, 32'd5));
    items_to_send.push_back(entry_item(CMD_WRITE, 4'd15, 32'hFFFF_FFFF));
    items_to_send.push_back(entry_item(CMD_READ, 4'd12, 32'd0));
    items_to_send.push_back(entry_item(CMD_READ, 4'd15, 32'd0));
    items_to_send.push_back(entry_item(CMD_WRITE, 4'd0, 32'hFFFF_FFFF));
    items_to_send.push_back(entry_item(CMD_WRITE, 4'd11, 32'd1));
    items_to_send.push_back(entry_item(CMD_NONE, 4'd0, 32'd0));
    drain();

    // full table searched: direct hit at extreme rssi/time, relayed hit, unwritten id 0
    write_reg(CFG_WATCH_COUNT, 9'd12);
    it = pkt_item(1'b0, 9'd64, 32'hFFFF_FFFF, 8'h21);
    it.rssi_half_db = -11'sd600;
    it.now_ms       = 32'hFFFF_FFFF;
    items_to_send.push_back(it);
    it = pkt_item(1'b0, 9'd64, 32'd1, 8'h60);
    it.rssi_half_db = 11'sd200;
    items_to_send.push_back(it);
    items_to_send.push_back(pkt_item(1'b0, 9'd64, 32'd0, 8'h00));
    items_to_send.push_back(entry_item(CMD_READ, 4'd0, 32'd0));
    items_to_send.push_back(entry_item(CMD_READ, 4'd11, 32'd0));
    items_to_send.push_back(entry_item(CMD_READ, 4'd1, 32'd0));
    drain();
    write_reg(CFG_WATCH_COUNT, 9'd15);
    write_reg(CFG_MIN_HDR_LEN, 9'd256);
    items_to_send.push_back(pkt_item(1'b0, 9'd255, 32'd1, 8'h00));
    items_to_send.push_back(pkt_item(1'b0, 9'd256, 32'd1, 8'h00));
    drain();
    write_reg(CFG_MIN_HDR_LEN, 9'd511);
    items_to_send.push_back(pkt_item(1'b0, 9'd300, 32'd1, 8'h00));
    drain();
    write_reg(CFG_MIN_HDR_LEN, 9'd0);
    items_to_send.push_back(pkt_item(1'b0, 9'd0, 32'd1, 8'h00));
    drain();

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_WATCH_COUNT, 9'(wc_plan[p]));
      write_reg(CFG_MIN_HDR_LEN, 9'(len_plan[p]));
      if (p == 0) hold_armed = 1'b1;
      phase_sent = 0;
      while (phase_sent < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 4) == 0) begin
          // load an entry, hear from that node a few times, read it back
          seq_idx = $urandom_range(0, ENTRIES - 1);
          seq_id  = $urandom | 32'd1;
          items_to_send.push_back(entry_item(CMD_WRITE, 4'(seq_idx), seq_id));
          known_ids.push_back(seq_id);
          phase_sent += 2;
          repeat ($urandom_range(2, 6)) begin
            it = pkt_item($urandom_range(0, 7) == 0,
                          (min_len_q <= MAX_LEN) ? 9'($urandom_range(min_len_q, 256))
                                                 : 9'($urandom),
                          seq_id, 8'($urandom));
            if ($urandom_range(0, 1) == 0) it.hop_flags[2:0] = it.hop_flags[7:5];
            items_to_send.push_back(it);
            phase_sent++;
          end
          items_to_send.push_back(entry_item(CMD_READ, 4'(seq_idx), 32'd0));
        end else begin
          repeat ($urandom_range(10, 40)) begin
            it   = noise_item();
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
              it.command      = CMD_PACKET;
              it.rx_crc_error = ($urandom_range(0, 9) == 0);
              case ($urandom_range(0, 4))
                0, 1: it.pkt_len = 9'($urandom_range(0, 40));
                2, 3: it.pkt_len = 9'($urandom_range(0, 256));
                default: it.pkt_len = 9'($urandom_range(0, 511));
              endcase
              roll = $urandom_range(0, 9);
              if (roll < 5 && known_ids.size() > 0)
                it.src_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
              else if (roll == 5)
                it.src_id = 32'd0;
              if ($urandom_range(0, 2) == 0) it.hop_flags[2:0] = it.hop_flags[7:5];
            end else if (pick < 78) begin
              it.command     = CMD_WRITE;
              it.entry_index = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                                           : 4'($urandom_range(0, 11));
              roll = $urandom_range(0, 9);
              if (roll == 0)
                it.entry_id = 32'd0;
              else if (roll < 4 && known_ids.size() > 0)
                it.entry_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
              if (it.entry_id != 32'd0) begin
                known_ids.push_back(it.entry_id);
                if (known_ids.size() > 20) void'(known_ids.pop_front());
              end
            end else if (pick < 95) begin
              it.command     = CMD_READ;
              it.entry_index = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                                           : 4'($urandom_range(0, 11));
            end else begin
              it.command = CMD_NONE;
            end
            items_to_send.push_back(it);
            if (it.command != CMD_NONE) phase_sent++;
          end
        end
        // sender sits out until the block has delivered everything
        if ($urandom_range(0, 3) == 0) drain();
      end
      drain();
    end

    drain();
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
      mismatches += expected_reports.size();
    end
    $display("Checked %0d results from %0d items over %0d register writes, %0d mismatches",
             results_checked, items_accepted, reg_writes, mismatches);
    $display("heard %0d (watch hits %0d), crc %0d, runt %0d, written %0d, rejected %0d, read %0d",
             kind_tally[KIND_HEARD], watch_hits, kind_tally[KIND_CRC], kind_tally[KIND_RUNT],
             kind_tally[KIND_WRITTEN], kind_tally[KIND_REJECT], kind_tally[KIND_READ]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
